[rtl/slp_pkg.sv]
`timescale 1ns / 1ps

package slp_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    typedef struct packed {
        logic [15:0] record_tag;
        logic [15:0] sort_key;
    } t_in_item;

    typedef struct packed {
        logic [15:0] out_tag;
        logic [15:0] out_key;
        logic        descending_pass;
        logic        last_of_run;
        logic        dropped;
    } t_out_item;

    typedef struct packed {
        logic [15:0]         tag;
        logic [KEY_BITS-1:0] key;
    } t_entry;

    function automatic logic [KEY_BITS-1:0] to_key(input logic [15:0] k);
        logic [47:0] w;
        w = {32'b0, k};
        return w[KEY_BITS-1:0];
    endfunction

    function automatic logic [15:0] from_key(input logic [KEY_BITS-1:0] k);
        logic [KEY_BITS+15:0] w;
        w = {16'b0, k};
        return w[15:0];
    endfunction

endpackage

[rtl/slp_cell.sv]
`timescale 1ns / 1ps

module slp_cell (
    input  logic            i_clk,
    input  logic            i_ins,
    input  logic            i_occ,
    input  slp_pkg::t_entry i_new,
    input  slp_pkg::t_entry i_prev,
    input  logic            i_prev_keep,
    output slp_pkg::t_entry o_entry,
    output logic            o_keep
);
    import slp_pkg::*;

    t_entry r_entry;

    // A cell keeps its entry when that entry is stored and sorts before the new one.
    assign o_keep  = i_occ && (r_entry.key < i_new.key);
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ins && !o_keep) begin
            r_entry <= i_prev_keep ? i_new : i_prev;
        end
    end

endmodule

[rtl/sorted_insert_list.sv]
`timescale 1ns / 1ps

// Sorted insert list. Each input item carries a tag and a key; the record is
// placed into a row of cells kept in ascending key order, ahead of any equal
// keys. Both channels use valid and stall; an item moves on a clock edge where
// valid is high and stall is low.
// After an insert the block lists all n stored entries ascending, then all n
// descending, setting descending_pass on the descending items and last_of_run
// on the final item. The insert is written into the cells on the accept edge,
// which also moves the state to listing; the single read port then walks the
// cells into the output register one per cycle while output stall is low.
// When the list already holds CAPACITY entries, the input is refused and one
// result with dropped set is shown in the cycle after acceptance.
// Input is stalled while a listing runs and while an undelivered result waits
// under output stall. A stalled result holds its value until taken.
// Synchronous reset empties the list and clears the output valid flag; stored
// entries keep whatever they held and are never read before written again.
module sorted_insert_list (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  slp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output slp_pkg::t_out_item o_out_data
);
    import slp_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LIST = 1'b1;

    logic             r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_idx;
    logic             r_desc;
    logic             r_out_valid;
    t_out_item        r_out;

    t_entry w_new;
    t_entry w_entry [CAPACITY];
    logic   w_keep  [CAPACITY];
    logic   w_ins;
    logic   w_full;
    logic   w_adv;
    logic   w_acc;
    t_entry w_rd;

    assign w_new.tag   = i_in_data.record_tag;
    assign w_new.key   = to_key(i_in_data.sort_key);
    assign w_full      = (r_cnt == CNT_W'(CAPACITY));
    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_acc       = i_in_valid && !o_in_stall;
    assign w_ins       = w_acc && !w_full;
    assign w_adv       = !r_out_valid || !i_out_stall;
    assign w_rd        = w_entry[r_idx];
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        slp_cell u_cell (
            .i_clk      (i_clk),
            .i_ins      (w_ins),
            .i_occ      (CNT_W'(g) < r_cnt),
            .i_new      (w_new),
            .i_prev     ((g == 0) ? w_new : w_entry[(g == 0) ? 0 : g - 1]),
            .i_prev_keep((g == 0) ? 1'b1 : w_keep[(g == 0) ? 0 : g - 1]),
            .o_entry    (w_entry[g]),
            .o_keep     (w_keep[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_desc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_adv) begin
                        r_out_valid <= 1'b0;
                    end
                    if (w_acc) begin
                        if (w_full) begin
                            r_out_valid           <= 1'b1;
                            r_out.out_tag         <= i_in_data.record_tag;
                            r_out.out_key         <= from_key(w_new.key);
                            r_out.descending_pass <= 1'b0;
                            r_out.last_of_run     <= 1'b1;
                            r_out.dropped         <= 1'b1;
                        end else begin
                            r_cnt   <= r_cnt + 1'b1;
                            r_idx   <= '0;
                            r_desc  <= 1'b0;
                            r_state <= S_LIST;
                        end
                    end
                end
                S_LIST: begin
                    if (w_adv) begin
                        r_out_valid           <= 1'b1;
                        r_out.out_tag         <= w_rd.tag;
                        r_out.out_key         <= from_key(w_rd.key);
                        r_out.descending_pass <= r_desc;
                        r_out.last_of_run     <= r_desc && (r_idx == '0);
                        r_out.dropped         <= 1'b0;
                        if (!r_desc) begin
                            if (CNT_W'(r_idx) == r_cnt - 1'b1) begin
                                r_desc <= 1'b1;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end else if (r_idx == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx - 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/slp_check.sv]
`timescale 1ns / 1ps

module slp_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input slp_pkg::t_out_item o_out_data
);
    import slp_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.dropped |->
            o_out_data.last_of_run && !o_out_data.descending_pass)
        else $error("dropped result is not a single final ascending item");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last_of_run |-> o_in_stall)
        else $error("input taken during a listing");

    a_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall || o_out_valid)
        else $error("accepted item produced no activity");

endmodule

bind sorted_insert_list slp_check u_slp_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    import slp_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int NUM_PHASES = 8;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    t_in_item  pending_items[$];
    t_out_item expected_rows[$];
    t_entry    shadow_list[CAPACITY];
    int        shadow_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        fail_count = 0;
    int        quiet_cycles = 0;

    sorted_insert_list uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_out_item make_row(input logic [15:0] tag,
                                           input logic [KEY_BITS-1:0] key,
                                           input logic desc, input logic last,
                                           input logic drop);
        t_out_item   row;
        logic [31:0] wide;
        wide = '0;
        wide[KEY_BITS-1:0] = key;
        row.out_tag = tag;
        row.out_key = wide[15:0];
        row.descending_pass = desc;
        row.last_of_run = last;
        row.dropped = drop;
        return row;
    endfunction

    task automatic append_row(input t_out_item row);
        expected_rows.insert(expected_rows.size(), row);
    endtask

    // Newest record goes ahead of any entry with an equal key.
    task automatic insert_and_list(input t_in_item item);
        logic [31:0]         wide;
        logic [KEY_BITS-1:0] key;
        int                  pos;
        wide = {16'b0, item.sort_key};
        key = wide[KEY_BITS-1:0];
        if (shadow_count >= CAPACITY) begin
            append_row(make_row(item.record_tag, key, 1'b0, 1'b1, 1'b1));
        end else begin
            pos = shadow_count;
            for (int j = 0; j < shadow_count; j++) begin
                if (shadow_list[j].key >= key) begin
                    pos = j;
                    break;
                end
            end
            for (int j = shadow_count; j > pos; j--) begin
                shadow_list[j] = shadow_list[j-1];
            end
            shadow_list[pos].tag = item.record_tag;
            shadow_list[pos].key = key;
            shadow_count++;
            for (int j = 0; j < shadow_count; j++) begin
                append_row(make_row(shadow_list[j].tag, shadow_list[j].key,
                                    1'b0, 1'b0, 1'b0));
            end
            for (int j = shadow_count - 1; j >= 0; j--) begin
                append_row(make_row(shadow_list[j].tag, shadow_list[j].key,
                                    1'b1, j == 0, 1'b0));
            end
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                insert_and_list(i_in_data);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_items.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_rows.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_out_data);
                    fail_count++;
                end else begin
                    want = expected_rows.pop_front();
                    check_field("out_tag", want.out_tag, o_out_data.out_tag);
                    check_field("out_key", want.out_key, o_out_data.out_key);
                    check_field("descending_pass", 16'(want.descending_pass),
                                16'(o_out_data.descending_pass));
                    check_field("last_of_run", 16'(want.last_of_run),
                                16'(o_out_data.last_of_run));
                    check_field("dropped", 16'(want.dropped), 16'(o_out_data.dropped));
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(negedge i_clk);
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic add_item(input logic [15:0] tag, input logic [15:0] key);
        t_in_item item;
        item.record_tag = tag;
        item.sort_key = key;
        pending_items.insert(pending_items.size(), item);
    endtask

    initial begin
        t_in_item    plan[$];
        int          phase_len[NUM_PHASES];
        int          send_mode[4];
        int          recv_mode[4];
        int          next;
        logic [31:0] r;
        logic [31:0] r2;

        phase_len = '{4, 4, 4, 8, 25, 25, 25, 25};
        send_mode = '{0, 82, 0, 8};
        recv_mode = '{0, 0, 82, 8};

        // The list fills after CAPACITY inserts; everything after that is refused.
        add_item(16'h0000, 16'h8000);
        add_item(16'hFFFF, 16'h8000);
        add_item(16'h0001, 16'h0000);
        add_item(16'h0002, 16'hFFFF);
        add_item(16'h0003, 16'hFFFF);
        add_item(16'h0004, 16'h0000);
        for (int i = 0; i < CAPACITY - 6; i++) begin
            r = $urandom;
            r2 = $urandom;
            if (r2[0]) begin
                add_item(r[15:0], r[31:16]);
            end else begin
                add_item(r[15:0], {r2[2:1], 14'b0});
            end
        end
        add_item(16'h0000, 16'h0000);
        add_item(16'hFFFF, 16'hFFFF);
        add_item(16'h5555, 16'hAAAA);
        add_item(16'hAAAA, 16'h5555);
        for (int i = 0; i < 100; i++) begin
            r = $urandom;
            add_item(r[15:0], r[31:16]);
        end
        plan = pending_items;
        pending_items.delete();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        next = 0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            @(negedge i_clk);
            send_idle_pct = send_mode[p % 4];
            recv_stall_pct = recv_mode[p % 4];
            for (int i = 0; i < phase_len[p] && next < plan.size(); i++) begin
                pending_items.insert(pending_items.size(), plan[next]);
                next++;
            end
            while (pending_items.size() > 0 || i_in_valid || expected_rows.size() > 0) begin
                @(negedge i_clk);
            end
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && expected_rows.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/slp_pkg.sv
rtl/slp_cell.sv
rtl/sorted_insert_list.sv
rtl/slp_check.sv
dv/tb_top.sv
